/* design/ecc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Euler circuit checker.
// Used by ecc_tables, ecc_seq and euler_circuit_checker_unit; depends on nothing.
package ecc_pkg;

  // Default table depth and fixed field widths
  localparam int MAX_NODES_DEF = 1024;
  localparam int NODE_W        = 10;
  localparam int S_TDATA_W     = 24;
  localparam int M_TDATA_W     = 8;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FIND_RD,
    ST_FIND_DATA,
    ST_LINK,
    ST_SCAN,
    ST_DRAIN,
    ST_ANSWER
  } state_t;

  // Table access strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic par_we;
    logic link_we;
  } tbl_ctrl_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } seq_stat_t;

endpackage

/* design/ecc_tables.sv */
`timescale 1ns / 1ps
// Parity and union-find parent tables, each a synchronous memory with registered reads.
// Depends on ecc_pkg for the access strobe struct.
module ecc_tables import ecc_pkg::*; #(
  parameter int DEPTH = MAX_NODES_DEF,
  parameter int AW    = $clog2(MAX_NODES_DEF)
) (
  input  logic          clk,
  input  tbl_ctrl_t     ctrl,
  input  logic [AW-1:0] raddr,
  input  logic [AW-1:0] par_waddr,
  input  logic          par_wdata,
  input  logic [AW-1:0] link_waddr,
  input  logic [AW-1:0] link_wdata,
  output logic          par_rdata,
  output logic [AW-1:0] link_rdata
);

  logic          par_mem  [DEPTH];
  logic [AW-1:0] link_mem [DEPTH];

  // Degree parity table: a read in the same cycle as a write returns the old value.
  always_ff @(posedge clk) begin
    if (ctrl.par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (ctrl.rd_en) begin
      par_rdata <= par_mem[raddr];
    end
  end

  // Parent table for the union-find forest.
  always_ff @(posedge clk) begin
    if (ctrl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ctrl.rd_en) begin
      link_rdata <= link_mem[raddr];
    end
  end

endmodule

/* design/ecc_seq.sv */
`timescale 1ns / 1ps
// Sequencer: range check, parity toggles, root walks, merge, final scan and table clearing.
// Depends on ecc_pkg; drives the ports of ecc_tables.
module ecc_seq import ecc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int AW        = $clog2(MAX_NODES_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [NODE_W-1:0] node_count,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NODE_W-1:0] in_a,
  input  logic [NODE_W-1:0] in_b,
  input  logic              in_edge,
  input  logic              in_last,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              res_circuit,
  output logic              res_bad,
  output tbl_ctrl_t         tbl_ctrl,
  output logic [AW-1:0]     raddr,
  output logic [AW-1:0]     par_waddr,
  output logic              par_wdata,
  output logic [AW-1:0]     link_waddr,
  output logic [AW-1:0]     link_wdata,
  input  logic              par_rdata,
  input  logic [AW-1:0]     link_rdata,
  output seq_stat_t         stat
);

  localparam int CW = ((AW > NODE_W) ? AW : NODE_W) + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);
  localparam logic [AW-1:0] FIRST_NODE = AW'(1);

  state_t state, state_next;

  logic [NODE_W-1:0] ea, eb;
  logic              edge_q, last_q;
  logic [AW-1:0]     cur, ra, rb, cnt, scan_idx;
  logic              bsel, first, scan_v, ok, err;

  logic [CW-1:0] nc_ext;
  logic [AW-1:0] n_lim;
  logic          bad_a, bad_b, bad_edge, root_hit;
  logic [AW-1:0] a_idx, b_idx;

  // Node count clamped to the table, and the endpoint range test
  always_comb begin
    nc_ext   = CW'(node_count);
    n_lim    = (nc_ext > CW'(MAX_NODES - 1)) ? LAST_IDX : AW'(nc_ext);
    bad_a    = (ea == '0) || (CW'(ea) > CW'(n_lim));
    bad_b    = (eb == '0) || (CW'(eb) > CW'(n_lim));
    bad_edge = bad_a || bad_b;
    a_idx    = AW'(ea);
    b_idx    = AW'(eb);
    root_hit = (link_rdata == cur);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cnt == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (edge_q && !bad_edge) state_next = ST_FIND_RD;
        else if (last_q)         state_next = (n_lim == '0) ? ST_ANSWER : ST_SCAN;
        else                     state_next = ST_IDLE;
      end
      ST_FIND_RD: state_next = ST_FIND_DATA;
      ST_FIND_DATA: begin
        if (root_hit && bsel) state_next = ST_LINK;
        else                  state_next = ST_FIND_RD;
      end
      ST_LINK: begin
        if (last_q) state_next = (n_lim == '0) ? ST_ANSWER : ST_SCAN;
        else        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt == n_lim) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_ANSWER;
      ST_ANSWER: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs: table strobes, addresses, handshakes
  always_comb begin
    tbl_ctrl   = '0;
    raddr      = cur;
    par_waddr  = cnt;
    par_wdata  = 1'b0;
    link_waddr = cnt;
    link_wdata = cnt;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        tbl_ctrl.par_we  = 1'b1;
        tbl_ctrl.link_we = 1'b1;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_FIND_RD: tbl_ctrl.rd_en = 1'b1;
      ST_FIND_DATA: begin
        // A self-loop toggles twice, so its parity is left alone
        tbl_ctrl.par_we = first && (ea != eb);
        par_waddr       = cur;
        par_wdata       = ~par_rdata;
      end
      ST_LINK: begin
        // The larger root is hung under the smaller one
        tbl_ctrl.link_we = (ra != rb);
        link_waddr       = (ra < rb) ? rb : ra;
        link_wdata       = (ra < rb) ? ra : rb;
      end
      ST_SCAN: begin
        // Read each node and return it to its reset value in the same cycle
        tbl_ctrl.rd_en   = 1'b1;
        tbl_ctrl.par_we  = 1'b1;
        tbl_ctrl.link_we = 1'b1;
        raddr            = cnt;
      end
      ST_ANSWER: res_valid = 1'b1;
      default: ;
    endcase
    res_circuit   = ok && !err;
    res_bad       = err;
    stat.clearing = (state == ST_CLEAR);
    stat.busy     = (state != ST_IDLE);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Item fields, walk pointers and scan result
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      err    <= 1'b0;
      scan_v <= 1'b0;
      first  <= 1'b0;
      bsel   <= 1'b0;
    end else begin
      scan_v <= (state == ST_SCAN);
      unique case (state)
        ST_CLEAR: cnt <= cnt + FIRST_NODE;
        ST_IDLE: begin
          if (in_valid) begin
            ea     <= in_a;
            eb     <= in_b;
            edge_q <= in_edge;
            last_q <= in_last;
          end
        end
        ST_CHECK: begin
          cnt   <= FIRST_NODE;
          ok    <= 1'b1;
          cur   <= a_idx;
          bsel  <= 1'b0;
          first <= 1'b1;
          if (edge_q && bad_edge) err <= 1'b1;
        end
        ST_FIND_DATA: begin
          // The end of the first walk starts the second one from the other endpoint
          if (root_hit && !bsel) begin
            ra    <= cur;
            cur   <= b_idx;
            bsel  <= 1'b1;
            first <= 1'b1;
          end else begin
            first <= 1'b0;
            if (root_hit) begin
              rb <= cur;
            end else begin
              cur <= link_rdata;
            end
          end
        end
        ST_SCAN: begin
          cnt      <= cnt + FIRST_NODE;
          scan_idx <= cnt;
        end
        ST_ANSWER: begin
          if (res_ready) err <= 1'b0;
        end
        default: ;
      endcase
      // Nodes are scanned upwards, so a node above 1 is connected when it has a parent
      if (scan_v && (par_rdata || ((scan_idx != FIRST_NODE) && (link_rdata == scan_idx)))) begin
        ok <= 1'b0;
      end
    end
  end

endmodule

/* design/euler_circuit_checker_unit.sv */
`timescale 1ns / 1ps
// Top level of the Euler circuit checker: configuration register, stream ports, result register.
// Depends on ecc_pkg, ecc_tables and ecc_seq.
//
// Usage: write node_count through cfg_we/cfg_wdata while the block is idle. Each input beat
// on the s_axis channel carries one edge (end_a, end_b) with has_edge in tuser; the beat
// with tlast high closes the graph. One beat on m_axis then gives has_circuit and
// bad_node, after which both tables are back at their reset contents.
// Steps: a beat that does not close the graph and carries no usable edge passes through
// the check state only. An edge adds a read and a data state for each node visited on the
// two root walks in the parent table (one memory read each), then the link state. The
// closing beat then scans nodes 1 to node_count (clamped to MAX_NODES-1), one read of both
// tables per node and cycle, then passes the drain and answer states, from which the result
// goes into the output register (the scan is skipped when node_count is zero).
// After reset the block steps through every table entry, setting it to its reset
// value; s_axis_tready stays low meanwhile, configuration writes are taken.
// The result sits in an output register: while m_axis_tready is low the next graph can
// already be loaded, and only a further answer waits until the register is taken.
module euler_circuit_checker_unit import ecc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [NODE_W-1:0]    cfg_wdata,      // node_count
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [9:0] end_a, [19:10] end_b, [23:20] zero
  input  logic                 s_axis_tuser,   // [0] has_edge
  input  logic                 s_axis_tlast,   // last_item
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [0] has_circuit, [1] bad_node, [7:2] zero
);

  localparam int AW = $clog2(MAX_NODES);

  logic [NODE_W-1:0] node_count;
  logic              res_valid, res_ready, res_circuit, res_bad;
  logic              has_circuit, bad_node;
  tbl_ctrl_t         tbl_ctrl;
  seq_stat_t         stat;
  logic [AW-1:0]     raddr, par_waddr, link_waddr, link_wdata, link_rdata;
  logic              par_wdata, par_rdata;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst)         node_count <= NODE_W'(1);
    else if (cfg_we) node_count <= cfg_wdata;
  end

  ecc_seq #(
    .MAX_NODES (MAX_NODES),
    .AW        (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .node_count  (node_count),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_a        (s_axis_tdata[NODE_W-1:0]),
    .in_b        (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .in_edge     (s_axis_tuser),
    .in_last     (s_axis_tlast),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_circuit (res_circuit),
    .res_bad     (res_bad),
    .tbl_ctrl    (tbl_ctrl),
    .raddr       (raddr),
    .par_waddr   (par_waddr),
    .par_wdata   (par_wdata),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .par_rdata   (par_rdata),
    .link_rdata  (link_rdata),
    .stat        (stat)
  );

  ecc_tables #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_tables (
    .clk        (clk),
    .ctrl       (tbl_ctrl),
    .raddr      (raddr),
    .par_waddr  (par_waddr),
    .par_wdata  (par_wdata),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .par_rdata  (par_rdata),
    .link_rdata (link_rdata)
  );

  // Output register: takes a new answer whenever it is empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      has_circuit <= res_circuit;
      bad_node    <= res_bad;
    end
  end

  assign m_axis_tdata = {{(M_TDATA_W-2){1'b0}}, bad_node, has_circuit};

  // No edge may be taken while the tables are still being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !s_axis_tready)
    else $error("input accepted during table clearing");

  // An answer handed over always lands in the output register
  a_answer_lands: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("answer lost on its way to the output register");

  // A range error never comes with a positive verdict
  a_bad_excludes_circuit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> !m_axis_tdata[0])
    else $error("has_circuit set together with bad_node");

  // No answer is pending while the sequencer is idle and ready for input
  a_idle_after_answer: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tready && !stat.busy) |-> !res_valid)
    else $error("input ready while an answer is pending");

endmodule
